[rtl/gfn_pkg.sv]
// shared types, constants and helpers for the grid flood fill navigator
// no dependencies; imported by every rtl module of the block
package gfn_pkg;

  localparam int GRID_SIDE  = 16;
  localparam int DIST_WIDTH = 9;
  localparam int NCELLS     = GRID_SIDE * GRID_SIDE;
  localparam int CELL_W     = $clog2(NCELLS);
  localparam int PTR_W      = CELL_W + 1;
  localparam int CRD_W      = $clog2(GRID_SIDE);
  localparam int OUT_W      = 9;
  localparam int OUT_INF    = 511;
  localparam logic [DIST_WIDTH-1:0] DIST_INF = {DIST_WIDTH{1'b1}};

  localparam logic [2:0] OP_WALL   = 3'd0;
  localparam logic [2:0] OP_SEED   = 3'd1;
  localparam logic [2:0] OP_RUN    = 3'd2;
  localparam logic [2:0] OP_CHOOSE = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [3:0] wall_mask;
    logic [1:0] heading;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       best_direction;
    logic [OUT_W-1:0] distance;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLR_STEP,
    DP_INF_STEP,
    DP_WALL_WR,
    DP_SEED,
    DP_QRD_IDX,
    DP_ZERO,
    DP_QRD_HEAD,
    DP_CUR_RD,
    DP_CUR_LAT,
    DP_CELL_RD,
    DP_CELL_LAT,
    DP_NB_RD,
    DP_NB_EVAL,
    DP_RUN_END
  } dp_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic zero_done;
    logic bfs_done;
    logic nd_sat;
    logic k_last;
  } dp_status_t;

  function automatic logic [1:0] turn_ofs(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      2'd0:    r = 2'd0;
      2'd1:    r = 2'd3;
      2'd2:    r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic coord_ok(input logic [3:0] c);
    return int'(c) < GRID_SIDE;
  endfunction

  function automatic logic [CELL_W-1:0] cell_of(input logic [3:0] x, input logic [3:0] y);
    return CELL_W'(int'(y) * GRID_SIDE + int'(x));
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic [DIST_WIDTH-1:0] d);
    logic [OUT_W-1:0] r;
    if (d >= DIST_WIDTH'(OUT_INF)) r = OUT_W'(OUT_INF);
    else r = d[OUT_W-1:0];
    return r;
  endfunction

endpackage

[rtl/gfn_datapath.sv]
// datapath: wall, distance and queue memories, pointers and result register
// depends on gfn_pkg; driven by gfn_controller commands
module gfn_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  gfn_pkg::dp_cmd_t   cmd,
  input  gfn_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  output gfn_pkg::dp_status_t status,
  output logic               out_valid,
  output gfn_pkg::out_item_t out_data
);
  import gfn_pkg::*;

  logic [3:0]            wall_mem [NCELLS];
  logic [DIST_WIDTH-1:0] dist_mem [NCELLS];
  logic [CELL_W-1:0]     queue_mem [NCELLS];

  in_item_t              in_r;
  logic                  prefer_r;
  logic [PTR_W-1:0]      idx_r, head_r, tail_r;
  logic [NCELLS-1:0]     seed_r;
  logic [3:0]            wall_q;
  logic [DIST_WIDTH-1:0] dist_q;
  logic [CELL_W-1:0]     q_q;
  logic [CELL_W-1:0]     ctr_cell_r;
  logic                  ctr_ok_r;
  logic [3:0]            ctr_wall_r;
  logic [DIST_WIDTH-1:0] nd_r, best_r;
  logic [1:0]            k_r, bdir_r, nb_dir_r;
  logic                  nb_ok_r;
  logic [CELL_W-1:0]     nb_cell_r;
  logic                  out_valid_r;

  logic                  in_ok;
  logic [CELL_W-1:0]     in_cell;
  logic [CRD_W-1:0]      cx, cy;
  logic [1:0]            dir;
  logic                  nb_ok;
  logic [CELL_W-1:0]     nb_cell;
  logic [DIST_WIDTH:0]   nd_wide;
  logic                  relax, do_enq, seed_new;

  logic                  dist_we, wall_we, queue_we, dist_re, wall_re, queue_re;
  logic [CELL_W-1:0]     dist_wa, dist_ra, wall_wa, wall_ra, queue_wa, queue_ra;
  logic [DIST_WIDTH-1:0] dist_wd;
  logic [3:0]            wall_wd;
  logic [CELL_W-1:0]     queue_wd;

  assign in_ok   = coord_ok(in_r.cell_x) && coord_ok(in_r.cell_y);
  assign in_cell = in_ok ? cell_of(in_r.cell_x, in_r.cell_y) : '0;
  assign cx      = CRD_W'(ctr_cell_r % GRID_SIDE);
  assign cy      = CRD_W'(ctr_cell_r / GRID_SIDE);
  assign dir     = (in_r.operation == OP_CHOOSE && prefer_r) ?
                   2'(in_r.heading + turn_ofs(k_r)) : k_r;
  assign nd_wide = {1'b0, dist_q} + 1'b1;
  assign seed_new = in_ok && !seed_r[in_cell];
  assign relax   = nb_ok_r && (dist_q > nd_r);
  assign do_enq  = relax && (tail_r < PTR_W'(NCELLS));

  always_comb begin
    nb_ok   = 1'b0;
    nb_cell = ctr_cell_r;
    case (dir)
      2'd0: begin
        nb_ok   = int'(cy) < GRID_SIDE - 1;
        nb_cell = ctr_cell_r + CELL_W'(GRID_SIDE);
      end
      2'd1: begin
        nb_ok   = int'(cx) < GRID_SIDE - 1;
        nb_cell = ctr_cell_r + 1'b1;
      end
      2'd2: begin
        nb_ok   = cy != '0;
        nb_cell = ctr_cell_r - CELL_W'(GRID_SIDE);
      end
      default: begin
        nb_ok   = cx != '0;
        nb_cell = ctr_cell_r - 1'b1;
      end
    endcase
    nb_ok = nb_ok && ctr_ok_r && !ctr_wall_r[dir];
  end

  always_comb begin
    dist_we  = 1'b0;
    dist_wa  = idx_r[CELL_W-1:0];
    dist_wd  = DIST_INF;
    wall_we  = 1'b0;
    wall_wa  = idx_r[CELL_W-1:0];
    wall_wd  = '0;
    queue_we = 1'b0;
    queue_wa = tail_r[CELL_W-1:0];
    queue_wd = in_cell;
    dist_re  = 1'b0;
    dist_ra  = in_cell;
    wall_re  = 1'b0;
    wall_ra  = in_cell;
    queue_re = 1'b0;
    queue_ra = idx_r[CELL_W-1:0];
    unique case (cmd)
      DP_CLR_STEP: begin
        dist_we = 1'b1;
        wall_we = 1'b1;
      end
      DP_INF_STEP: dist_we = 1'b1;
      DP_WALL_WR: begin
        wall_we = in_ok;
        wall_wa = in_cell;
        wall_wd = in_r.wall_mask;
      end
      DP_SEED: queue_we = seed_new && (tail_r < PTR_W'(NCELLS));
      DP_QRD_IDX: queue_re = 1'b1;
      DP_QRD_HEAD: begin
        queue_re = 1'b1;
        queue_ra = head_r[CELL_W-1:0];
      end
      DP_ZERO: begin
        dist_we = 1'b1;
        dist_wa = q_q;
        dist_wd = '0;
      end
      DP_CUR_RD: begin
        dist_re = 1'b1;
        dist_ra = q_q;
        wall_re = 1'b1;
        wall_ra = q_q;
      end
      DP_CELL_RD: begin
        dist_re = 1'b1;
        wall_re = 1'b1;
      end
      DP_NB_RD: begin
        dist_re = 1'b1;
        dist_ra = nb_cell;
      end
      DP_NB_EVAL: begin
        dist_we  = relax && in_r.operation == OP_RUN;
        dist_wa  = nb_cell_r;
        dist_wd  = nd_r;
        queue_we = do_enq && in_r.operation == OP_RUN;
        queue_wd = nb_cell_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    if (dist_re) dist_q <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk) begin
    if (wall_we) wall_mem[wall_wa] <= wall_wd;
    if (wall_re) wall_q <= wall_mem[wall_ra];
  end

  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    if (queue_re) q_q <= queue_mem[queue_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefer_r    <= 1'b1;
      idx_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      seed_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) prefer_r <= cfg_wdata;
      out_valid_r <= 1'b0;
      unique case (cmd)
        DP_LOAD: in_r <= in_data;
        DP_CLR_STEP, DP_INF_STEP: begin
          idx_r <= status.idx_last ? '0 : idx_r + 1'b1;
        end
        DP_SEED: begin
          if (seed_new) begin
            seed_r[in_cell] <= 1'b1;
            if (tail_r < PTR_W'(NCELLS)) tail_r <= tail_r + 1'b1;
          end
        end
        DP_ZERO: idx_r <= idx_r + 1'b1;
        DP_CUR_RD: begin
          ctr_cell_r <= q_q;
          ctr_ok_r   <= 1'b1;
          head_r     <= head_r + 1'b1;
        end
        DP_CUR_LAT: begin
          ctr_wall_r <= wall_q;
          nd_r       <= nd_wide[DIST_WIDTH-1:0];
          k_r        <= '0;
        end
        DP_CELL_RD: begin
          ctr_cell_r <= in_cell;
          ctr_ok_r   <= in_ok;
        end
        DP_CELL_LAT: begin
          ctr_wall_r <= wall_q;
          best_r     <= DIST_INF;
          bdir_r     <= in_r.heading;
          k_r        <= '0;
        end
        DP_NB_RD: begin
          nb_ok_r   <= nb_ok;
          nb_cell_r <= nb_cell;
          nb_dir_r  <= dir;
        end
        DP_NB_EVAL: begin
          k_r <= k_r + 1'b1;
          if (in_r.operation == OP_RUN) begin
            if (do_enq) tail_r <= tail_r + 1'b1;
          end else if (nb_ok_r && dist_q < best_r) begin
            best_r <= dist_q;
            bdir_r <= nb_dir_r;
          end
        end
        DP_RUN_END: begin
          head_r <= '0;
          tail_r <= '0;
          seed_r <= '0;
          idx_r  <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    out_data = '0;
    if (in_r.operation == OP_CHOOSE) begin
      out_data.best_direction = bdir_r;
      out_data.distance       = sat_out(best_r);
    end else if (in_r.operation == OP_READ) begin
      out_data.distance = in_ok ? sat_out(dist_q) : OUT_W'(OUT_INF);
    end
  end

  always_comb begin
    status.idx_last  = idx_r[CELL_W-1:0] == {CELL_W{1'b1}};
    status.zero_done = idx_r == tail_r;
    status.bfs_done  = head_r == tail_r;
    status.nd_sat    = nd_wide >= {1'b0, DIST_INF};
    status.k_last    = k_r == 2'd3;
  end

endmodule

[rtl/gfn_controller.sv]
// controller: sequences clear pass, table operations, flood run and choose
// depends on gfn_pkg; commands gfn_datapath
module gfn_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2:0]          op,
  input  gfn_pkg::dp_status_t status,
  output gfn_pkg::dp_cmd_t    cmd,
  output logic                busy,
  output logic                done
);
  import gfn_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_WALL, S_SEED, S_INF, S_ZQ, S_ZW, S_BQ, S_BC, S_BL,
    S_BNR, S_BNE, S_END, S_CR, S_CL, S_CNR, S_CNE, S_RR, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = DP_NOP;
    unique case (state_r)
      S_CLEAR: begin
        cmd = DP_CLR_STEP;
        if (status.idx_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd = DP_LOAD;
          unique case (op)
            OP_WALL:   state_nxt = S_WALL;
            OP_SEED:   state_nxt = S_SEED;
            OP_RUN:    state_nxt = S_INF;
            OP_CHOOSE: state_nxt = S_CR;
            OP_READ:   state_nxt = S_RR;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_WALL: begin
        cmd = DP_WALL_WR;
        state_nxt = S_DONE;
      end
      S_SEED: begin
        cmd = DP_SEED;
        state_nxt = S_DONE;
      end
      S_INF: begin
        cmd = DP_INF_STEP;
        if (status.idx_last) state_nxt = S_ZQ;
      end
      S_ZQ: begin
        if (status.zero_done) state_nxt = S_BQ;
        else begin
          cmd = DP_QRD_IDX;
          state_nxt = S_ZW;
        end
      end
      S_ZW: begin
        cmd = DP_ZERO;
        state_nxt = S_ZQ;
      end
      S_BQ: begin
        if (status.bfs_done) state_nxt = S_END;
        else begin
          cmd = DP_QRD_HEAD;
          state_nxt = S_BC;
        end
      end
      S_BC: begin
        cmd = DP_CUR_RD;
        state_nxt = S_BL;
      end
      S_BL: begin
        cmd = DP_CUR_LAT;
        state_nxt = status.nd_sat ? S_BQ : S_BNR;
      end
      S_BNR: begin
        cmd = DP_NB_RD;
        state_nxt = S_BNE;
      end
      S_BNE: begin
        cmd = DP_NB_EVAL;
        state_nxt = status.k_last ? S_BQ : S_BNR;
      end
      S_END: begin
        cmd = DP_RUN_END;
        state_nxt = S_DONE;
      end
      S_CR: begin
        cmd = DP_CELL_RD;
        state_nxt = S_CL;
      end
      S_CL: begin
        cmd = DP_CELL_LAT;
        state_nxt = S_CNR;
      end
      S_CNR: begin
        cmd = DP_NB_RD;
        state_nxt = S_CNE;
      end
      S_CNE: begin
        cmd = DP_NB_EVAL;
        state_nxt = status.k_last ? S_DONE : S_CNR;
      end
      S_RR: begin
        cmd = DP_CELL_RD;
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      done    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done    <= state_r == S_DONE;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

[rtl/grid_flood_fill_navigator_core.sv]
// top level of the grid flood fill navigator
// depends on gfn_pkg, gfn_controller and gfn_datapath
//
// After reset the block clears the wall and distance maps with busy high.
// A transaction is taken when start is high and busy is low; its result
// shows on out_data for one cycle with out_valid, which the receiver cannot
// stall. Every operation, unknown ones included, returns a result; choose
// does one distance memory read and compare per neighbor. Run sweeps the
// distance memory once, zeroes each queued seed, then dequeues cells one at a
// time and probes the neighbors of each.
module grid_flood_fill_navigator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  gfn_pkg::in_item_t  in_data,
  output logic               out_valid,
  output gfn_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import gfn_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       done;
  logic       dp_valid;

  gfn_controller u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .op     (in_data.operation),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  gfn_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .status    (status),
    .out_valid (dp_valid),
    .out_data  (out_data)
  );

  assign out_valid = done | dp_valid;

endmodule

[rtl/gfn_checker.sv]
// port-level checker for the grid flood fill navigator, bound to the top level
// depends on gfn_pkg
module gfn_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  import gfn_pkg::*;

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("transaction did not start");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");

endmodule

bind grid_flood_fill_navigator_core gfn_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

[tb/tb.sv]
// self-checking testbench for grid_flood_fill_navigator_core
// depends on gfn_pkg and the rtl of the block; predicts every result in a scoreboard
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gfn_pkg::*;

  class nav_scoreboard;
    logic [3:0] walls [NCELLS];
    int unsigned dmap [NCELLS];
    bit marks [NCELLS];
    int unsigned cq [NCELLS];
    int unsigned q_tail;
    bit straight;
    out_item_t pending[$];
    int errors;

    function void clear();
      for (int i = 0; i < NCELLS; i++) begin
        walls[i] = 0;
        dmap[i] = DIST_INF;
        marks[i] = 0;
        cq[i] = 0;
      end
      q_tail = 0;
      straight = 1;
      errors = 0;
    endfunction

    function void flood();
      int unsigned head, cur, nd, n;
      int cx, cy, nx, ny;
      for (int i = 0; i < NCELLS; i++) dmap[i] = DIST_INF;
      for (int i = 0; i < q_tail; i++) dmap[cq[i]] = 0;
      head = 0;
      while (head < q_tail) begin
        cur = cq[head];
        nd = dmap[cur] + 1;
        cx = cur % GRID_SIDE;
        cy = cur / GRID_SIDE;
        head++;
        if (nd >= DIST_INF) continue;
        for (int d = 0; d < 4; d++) begin
          if (walls[cur][d]) continue;
          nx = cx + int'(d == 1) - int'(d == 3);
          ny = cy + int'(d == 0) - int'(d == 2);
          if (nx < 0 || ny < 0 || nx >= GRID_SIDE || ny >= GRID_SIDE) continue;
          n = ny * GRID_SIDE + nx;
          if (dmap[n] > nd) begin
            dmap[n] = nd;
            if (q_tail < NCELLS) begin
              cq[q_tail] = n;
              q_tail++;
            end
          end
        end
      end
      q_tail = 0;
      for (int i = 0; i < NCELLS; i++) marks[i] = 0;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      bit ok;
      int unsigned cidx, best, v;
      logic [1:0] d, bdir;
      int nx, ny;
      r = '0;
      ok = (it.cell_x < GRID_SIDE) && (it.cell_y < GRID_SIDE);
      cidx = it.cell_y * GRID_SIDE + it.cell_x;
      case (it.operation)
        OP_WALL: if (ok) walls[cidx] = it.wall_mask;
        OP_SEED: begin
          if (ok && !marks[cidx]) begin
            marks[cidx] = 1;
            if (q_tail < NCELLS) begin
              cq[q_tail] = cidx;
              q_tail++;
            end
          end
        end
        OP_RUN: flood();
        OP_CHOOSE: begin
          best = DIST_INF;
          bdir = it.heading;
          if (ok) begin
            for (int i = 0; i < 4; i++) begin
              d = straight ? 2'(it.heading + turn_ofs(2'(i))) : 2'(i);
              if (walls[cidx][d]) continue;
              nx = int'(it.cell_x) + int'(d == 1) - int'(d == 3);
              ny = int'(it.cell_y) + int'(d == 0) - int'(d == 2);
              if (nx < 0 || ny < 0 || nx >= GRID_SIDE || ny >= GRID_SIDE) continue;
              v = dmap[ny * GRID_SIDE + nx];
              if (v < best) begin
                best = v;
                bdir = d;
              end
            end
          end
          r.best_direction = bdir;
          r.distance = best >= OUT_INF ? OUT_W'(OUT_INF) : OUT_W'(best);
        end
        OP_READ: r.distance = !ok ? OUT_W'(OUT_INF) :
                   (dmap[cidx] >= OUT_INF ? OUT_W'(OUT_INF) : OUT_W'(dmap[cidx]));
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d/%0d", $time,
                 got.best_direction, got.distance);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.best_direction !== want.best_direction) begin
        $display("%0t: best_direction expected %0d actual %0d", $time,
                 want.best_direction, got.best_direction);
        errors++;
      end
      if (got.distance !== want.distance) begin
        $display("%0t: distance expected %0d actual %0d", $time, want.distance, got.distance);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0, start = 0, cfg_we = 0, cfg_wdata = 0;
  logic busy, out_valid;
  in_item_t in_data = '0;
  out_item_t out_data;
  nav_scoreboard sb;
  int idle_pct;
  longint cycles;

  grid_flood_fill_navigator_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    sb = new();
    sb.clear();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) sb.check_result(out_data);
    if (cycles > 3000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_pref(bit v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.straight = v;
  endtask

  function automatic in_item_t mk(logic [2:0] op, int x, int y, int m, int h);
    in_item_t it;
    it.operation = op;
    it.cell_x = 4'(x);
    it.cell_y = 4'(y);
    it.wall_mask = 4'(m);
    it.heading = 2'(h);
    return it;
  endfunction

  function automatic in_item_t rnd_item();
    in_item_t it;
    int r;
    it.cell_x = 4'($urandom);
    it.cell_y = 4'($urandom);
    it.wall_mask = 4'($urandom);
    it.heading = 2'($urandom);
    r = $urandom_range(99);
    if (r < 35) it.operation = OP_WALL;
    else if (r < 50) it.operation = OP_SEED;
    else if (r < 53) it.operation = OP_RUN;
    else if (r < 78) it.operation = OP_CHOOSE;
    else if (r < 97) it.operation = OP_READ;
    else it.operation = 3'($urandom_range(7, 5));
    if (it.operation == OP_WALL && $urandom_range(1)) it.wall_mask &= 4'($urandom);
    return it;
  endfunction

  initial begin
    cycles = 0;
    idle_pct = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1;
    send(mk(OP_READ, 0, 0, 0, 0));
    send(mk(OP_CHOOSE, 5, 5, 0, 1));
    send(mk(OP_RUN, 0, 0, 0, 0));
    send(mk(OP_SEED, 0, 0, 0, 0));
    send(mk(OP_SEED, 0, 0, 0, 0));
    send(mk(OP_SEED, 15, 15, 0, 0));
    send(mk(OP_WALL, 15, 0, 15, 0));
    send(mk(OP_WALL, 1, 1, 4'b0101, 0));
    send(mk(OP_RUN, 0, 0, 0, 0));
    send(mk(OP_READ, 15, 15, 0, 0));
    send(mk(OP_READ, 15, 0, 0, 0));
    send(mk(OP_READ, 7, 8, 0, 0));
    send(mk(OP_CHOOSE, 1, 1, 0, 0));
    send(mk(OP_CHOOSE, 0, 0, 0, 2));
    send(mk(OP_CHOOSE, 15, 0, 0, 3));
    send(mk(OP_CHOOSE, 8, 8, 0, 3));
    send(mk(3'd5, 3, 3, 3, 3));
    send(mk(3'd7, 15, 15, 15, 3));
    set_pref(0);
    send(mk(OP_CHOOSE, 8, 8, 0, 3));
    send(mk(OP_CHOOSE, 15, 15, 0, 2));
    send(mk(OP_RUN, 0, 0, 0, 0));
    send(mk(OP_READ, 0, 0, 0, 0));
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 48 : (ph == 3) ? 30 : 0;
      set_pref(ph[0]);
      for (int i = 0; i < 300; i++) begin
        send(rnd_item());
        if (i == 150) drain();
      end
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
